[rtl/core/epfp_pkg.sv]
// ----------------------------------------------------------------------------
// epfp_pkg
// Shared types, mode codes and pixel helper functions of the e-paper pixel
// format packer.
// ----------------------------------------------------------------------------
`default_nettype none

package epfp_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [3:0] nibble_t;
	typedef logic [1:0] code_t;

	typedef enum logic [1:0] {
		MODE_MONO     = 2'd0,
		MODE_MONO_MIR = 2'd1,
		MODE_DIFF     = 2'd2,
		MODE_GRAY     = 2'd3
	} mode_t;

	// Up to two packed bytes caused by one input item.
	typedef struct packed {
		logic [1:0] count;
		byte_t      first;
		byte_t      second;
	} result_t;

	// Build four 2-bit codes; hi4 holds the code high bits, lo4 the low bits,
	// pixel 0 in bit 3 of each and in bits 7:6 of the result.
	function automatic byte_t spread_pairs(nibble_t hi4, nibble_t lo4);
		byte_t r;
		r = '0;
		for (int i = 0; i < 4; i++) begin
			r[7 - 2 * i] = hi4[3 - i];
			r[6 - 2 * i] = lo4[3 - i];
		end
		return r;
	endfunction

	function automatic byte_t reverse8(byte_t b);
		byte_t r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			r[i] = b[7 - i];
		end
		return r;
	endfunction

	// Indexes 0..3 pass through; higher ones fold by their upper bit pair.
	function automatic code_t gray_fold(nibble_t idx);
		code_t c;
		case (idx[3:2])
			2'd0: c = idx[1:0];
			2'd1: c = 2'b10;
			2'd2: c = 2'b01;
			default: c = 2'b11;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

[rtl/core/epfp_in_if.sv]
// ----------------------------------------------------------------------------
// epfp_in_if
// Input channel: one framebuffer byte, the previous-frame byte and row end.
// ----------------------------------------------------------------------------
`default_nettype none

interface epfp_in_if;
	import epfp_pkg::*;

	logic  valid;
	logic  ready;
	byte_t new_byte;
	byte_t old_byte;
	logic  row_end;

	modport source (output valid, output new_byte, output old_byte, output row_end,
		input ready);
	modport sink (input valid, input new_byte, input old_byte, input row_end,
		output ready);

endinterface

`default_nettype wire

[rtl/core/epfp_out_if.sv]
// ----------------------------------------------------------------------------
// epfp_out_if
// Output channel: one packed controller byte and its last-of-item mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface epfp_out_if;
	import epfp_pkg::*;

	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink (input valid, input out_byte, input last, output ready);

endinterface

`default_nettype wire

[rtl/core/epfp_format.sv]
// ----------------------------------------------------------------------------
// epfp_format
// Turns one registered input item into zero, one or two packed bytes and
// keeps the half-filled gray byte between items.
// ----------------------------------------------------------------------------
`default_nettype none

module epfp_format (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire epfp_pkg::mode_t mode,
	input  wire epfp_pkg::byte_t new_byte,
	input  wire epfp_pkg::byte_t old_byte,
	input  wire logic            row_end,
	input  wire logic            advance,
	output epfp_pkg::result_t    result
);
	import epfp_pkg::*;

	nibble_t gray_pending_q;
	logic    gray_half_full_q;
	nibble_t gray_two;
	byte_t   mono_b;
	byte_t   hi_b;
	byte_t   lo_b;

	assign gray_two = {gray_fold(new_byte[3:0]), gray_fold(new_byte[7:4])};
	assign mono_b   = (mode == MODE_MONO_MIR) ? reverse8(new_byte) : new_byte;
	assign hi_b     = (mode == MODE_DIFF) ? old_byte : mono_b;
	assign lo_b     = (mode == MODE_DIFF) ? new_byte : mono_b;

	always_comb begin
		result.count  = 2'd2;
		result.first  = spread_pairs(hi_b[7:4], lo_b[7:4]);
		result.second = spread_pairs(hi_b[3:0], lo_b[3:0]);
		if (mode == MODE_GRAY) begin
			result.second = '0;
			if (gray_half_full_q) begin
				result.count = 2'd1;
				result.first = {gray_pending_q, gray_two};
			end else if (row_end) begin
				result.count = 2'd1;
				result.first = {gray_two, 4'b0000};
			end else begin
				result.count = 2'd0;
				result.first = '0;
			end
		end
	end

	// Gray state only moves when an item in gray mode leaves this stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gray_pending_q   <= '0;
			gray_half_full_q <= 1'b0;
		end else if (advance && mode == MODE_GRAY) begin
			if (gray_half_full_q) begin
				gray_pending_q   <= '0;
				gray_half_full_q <= 1'b0;
			end else if (!row_end) begin
				gray_pending_q   <= gray_two;
				gray_half_full_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/epfp_out_buf.sv]
// ----------------------------------------------------------------------------
// epfp_out_buf
// Result register with a second slot, so that a two-byte result is handed
// out one byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module epfp_out_buf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire epfp_pkg::result_t result,
	output logic                   free,
	epfp_out_if.source             out_ch
);
	import epfp_pkg::*;

	logic  head_valid_q;
	logic  head_last_q;
	byte_t head_byte_q;
	logic  tail_valid_q;
	byte_t tail_byte_q;
	logic  take;

	assign take = head_valid_q && out_ch.ready;
	// The buffer can load when it is empty or its final byte leaves now.
	assign free = !head_valid_q || (take && !tail_valid_q);

	assign out_ch.valid    = head_valid_q;
	assign out_ch.out_byte = head_byte_q;
	assign out_ch.last     = head_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			tail_valid_q <= 1'b0;
		end else if (load) begin
			head_valid_q <= 1'b1;
			tail_valid_q <= (result.count == 2'd2);
		end else if (take) begin
			head_valid_q <= tail_valid_q;
			tail_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			head_byte_q <= result.first;
			head_last_q <= (result.count != 2'd2);
			tail_byte_q <= result.second;
		end else if (take) begin
			head_byte_q <= tail_byte_q;
			head_last_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

[rtl/core/epaper_pixel_format_packer_top.sv]
// ----------------------------------------------------------------------------
// epaper_pixel_format_packer_top
// Packs framebuffer bytes into 2-bit-per-pixel controller bytes in mono,
// mirrored mono, old/new diff or gray4 mode.
//
//   Channel   Direction  Payload
//   in_ch     sink       new_byte[7:0], old_byte[7:0], row_end
//   out_ch    source     out_byte[7:0], last
//   cfg       write only cfg_we, cfg_wdata[1:0] (pack_mode)
//
// An accepted item is held in the input register and then loads the result
// buffer, which offers its first byte on the output channel; an item
// without a result (a gray byte that is only stored) loads nothing.
// Mono and diff items give two bytes each on the one-byte output channel;
// gray items give one byte or none. Reset clears the mode to mono and drops
// any pending gray pixels. A stalled output holds the buffer, and the input
// register stays full until the buffer can take its result.
// ----------------------------------------------------------------------------
`default_nettype none

module epaper_pixel_format_packer_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_wdata,
	epfp_in_if.sink         in_ch,
	epfp_out_if.source      out_ch
);
	import epfp_pkg::*;

	mode_t   pack_mode_q;
	logic    valid_s1;
	byte_t   new_byte_s1;
	byte_t   old_byte_s1;
	logic    row_end_s1;
	result_t result;
	logic    buf_free;
	logic    go_s1;

	// Items without a result leave the input register regardless of the buffer.
	assign go_s1       = valid_s1 && (result.count == 2'd0 || buf_free);
	assign in_ch.ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_mode_q <= MODE_MONO;
		end else if (cfg_we) begin
			pack_mode_q <= mode_t'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			new_byte_s1 <= in_ch.new_byte;
			old_byte_s1 <= in_ch.old_byte;
			row_end_s1  <= in_ch.row_end;
		end
	end

	epfp_format u_format (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (pack_mode_q),
		.new_byte (new_byte_s1),
		.old_byte (old_byte_s1),
		.row_end  (row_end_s1),
		.advance  (go_s1),
		.result   (result)
	);

	epfp_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (go_s1 && result.count != 2'd0),
		.result (result),
		.free   (buf_free),
		.out_ch (out_ch)
	);

endmodule

`default_nettype wire

[dv/epfp_tb_pkg.sv]
// ----------------------------------------------------------------------------
// epfp_tb_pkg
// Controller byte tracker for the pixel format packer testbench. It keeps its
// own copy of the pack mode and the pending gray pixels, works out the bytes
// each accepted framebuffer byte must produce, and checks the outgoing bytes
// against them in order.
// ----------------------------------------------------------------------------
package epfp_tb_pkg;
	import epfp_pkg::*;

	typedef struct packed {
		byte_t data;
		logic  last;
	} ctrl_byte_t;

	class ctrl_byte_tracker;
		mode_t       mode;
		nibble_t     held_codes;
		bit          half_full;
		ctrl_byte_t  due_bytes[$];
		int unsigned bad_fields;
		int unsigned bytes_checked;
		int unsigned early_closes;

		function new();
			mode          = MODE_MONO;
			held_codes    = '0;
			half_full     = 1'b0;
			bad_fields    = 0;
			bytes_checked = 0;
			early_closes  = 0;
		endfunction

		// Code bit pairs land MSB first: pixel 0 in bits 7:6.
		static function byte_t interleave(nibble_t hi4, nibble_t lo4);
			return {hi4[3], lo4[3], hi4[2], lo4[2], hi4[1], lo4[1], hi4[0], lo4[0]};
		endfunction

		// Indexes above 3 map by their upper pair with its two bits swapped.
		static function code_t fold_gray(nibble_t idx);
			if (idx < 4'd4) begin
				return idx[1:0];
			end
			return {idx[2], idx[3]};
		endfunction

		function void push(byte_t data, logic last);
			due_bytes.push_back({data, last});
		endfunction

		function int unsigned due_count();
			return due_bytes.size();
		endfunction

		function void take_byte(byte_t nb, byte_t ob, logic re);
			nibble_t pair;
			byte_t   hi;
			byte_t   lo;
			if (mode == MODE_GRAY) begin
				// The row runs right to left, so the low nibble is the earlier pixel.
				pair = {fold_gray(nb[3:0]), fold_gray(nb[7:4])};
				if (half_full) begin
					push({held_codes, pair}, 1'b1);
					held_codes = '0;
					half_full  = 1'b0;
				end else if (re) begin
					push({pair, 4'h0}, 1'b1);
					early_closes++;
				end else begin
					held_codes = pair;
					half_full  = 1'b1;
				end
			end else begin
				if (mode == MODE_DIFF) begin
					hi = ob;
					lo = nb;
				end else if (mode == MODE_MONO_MIR) begin
					hi = {<<{nb}};
					lo = hi;
				end else begin
					hi = nb;
					lo = nb;
				end
				push(interleave(hi[7:4], lo[7:4]), 1'b0);
				push(interleave(hi[3:0], lo[3:0]), 1'b1);
			end
		endfunction

		function void flag(string msg);
			bad_fields++;
			if (bad_fields <= 10) begin
				$display("MISMATCH at %0t: %s", $time, msg);
			end
		endfunction

		function void check_byte(byte_t data, logic last);
			ctrl_byte_t want;
			bytes_checked++;
			if (due_bytes.size() == 0) begin
				flag($sformatf("unexpected controller byte %02h last %0b", data, last));
				return;
			end
			want = due_bytes.pop_front();
			if (data !== want.data) begin
				flag($sformatf("out_byte expected %02h, got %02h", want.data, data));
			end
			if (last !== want.last) begin
				flag($sformatf("last expected %0b, got %0b", want.last, last));
			end
		endfunction
	endclass

endpackage

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the e-paper pixel format packer. A directed
// sequence walks the byte extremes, all pack modes and the gray row-end cases,
// then random phases in every mode run with row-structured gray traffic,
// random gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import epfp_pkg::*;
	import epfp_tb_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 300000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned STALL_CYCLES  = 80;
	localparam int unsigned STALL_AT      = 300;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;

	epfp_in_if  in_if ();
	epfp_out_if out_if ();

	ctrl_byte_tracker tracker = new();

	bit          quiet;
	bit          pressure_done;
	int unsigned stall_left;
	int unsigned cycle_count;
	int unsigned results_seen;
	int unsigned items_sent;

	epaper_pixel_format_packer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_if),
		.out_ch    (out_if)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d bytes outstanding", cycle_count,
				tracker.due_count());
			$display("tb_top failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_if.valid && out_if.ready) begin
			tracker.check_byte(out_if.out_byte, out_if.last);
			results_seen++;
		end
	end

	// Output side: random back-pressure, plus one long hold-off that lets the
	// block fill up while the sender keeps offering transfers.
	initial begin : receiver
		out_if.ready  = 1'b0;
		pressure_done = 1'b0;
		stall_left    = 0;
		forever begin
			@(negedge clk);
			if (stall_left != 0) begin
				stall_left--;
				out_if.ready = 1'b0;
			end else if (!pressure_done && results_seen >= STALL_AT) begin
				pressure_done = 1'b1;
				stall_left    = STALL_CYCLES - 1;
				out_if.ready  = 1'b0;
			end else begin
				out_if.ready = quiet || ($urandom_range(0, 9) != 0);
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer
	// with valid still high.
	task automatic send_item(byte_t nb, byte_t ob, logic re);
		in_if.valid    = 1'b1;
		in_if.new_byte = nb;
		in_if.old_byte = ob;
		in_if.row_end  = re;
		@(posedge clk);
		while (!in_if.ready) begin
			@(posedge clk);
		end
		tracker.take_byte(nb, ob, re);
		items_sent++;
		@(negedge clk);
	endtask

	// A gray byte stored without a result may still be in flight when the
	// last expected byte leaves, so the write also waits out the SETTLE_CYCLES delay.
	task automatic apply_mode(mode_t m);
		in_if.valid = 1'b0;
		while (tracker.due_count() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = m;
		@(posedge clk);
		tracker.mode = m;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic run_phase(mode_t m, int unsigned count, bit calm);
		int unsigned row_len;
		int unsigned row_pos;
		byte_t       nb;
		byte_t       ob;
		logic        re;
		apply_mode(m);
		quiet   = calm;
		row_len = $urandom_range(1, 8);
		row_pos = 0;
		for (int unsigned i = 0; i < count; i++) begin
			if (!quiet && $urandom_range(0, 9) == 0) begin
				in_if.valid = 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
			nb = byte_t'($urandom_range(0, 255));
			ob = byte_t'($urandom_range(0, 255));
			if (m == MODE_GRAY) begin
				// Mostly proper rows of odd and even length; some row ends are
				// dropped or misplaced.
				re = (row_pos + 1 >= row_len);
				if ($urandom_range(0, 9) == 0) begin
					re = 1'($urandom_range(0, 1));
				end
				if (re) begin
					row_pos = 0;
					row_len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 41) :
						$urandom_range(1, 8);
				end else begin
					row_pos++;
				end
			end else begin
				re = 1'($urandom_range(0, 1));
			end
			send_item(nb, ob, re);
		end
		quiet = 1'b0;
	endtask

	initial begin : stimulus
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = MODE_MONO;
		in_if.valid    = 1'b0;
		in_if.new_byte = '0;
		in_if.old_byte = '0;
		in_if.row_end  = 1'b0;
		quiet          = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Mono straight from reset, then mirrored mono and diff extremes.
		send_item(8'h00, 8'h00, 1'b0);
		send_item(8'hFF, 8'h00, 1'b1);
		send_item(8'h80, 8'hFF, 1'b0);
		send_item(8'h01, 8'hA5, 1'b1);
		apply_mode(MODE_MONO_MIR);
		send_item(8'h80, 8'h00, 1'b0);
		send_item(8'h01, 8'hFF, 1'b1);
		send_item(8'hC5, 8'h3C, 1'b0);
		apply_mode(MODE_DIFF);
		send_item(8'h00, 8'hFF, 1'b0);
		send_item(8'hFF, 8'h00, 1'b1);
		send_item(8'hCC, 8'hF0, 1'b0);
		send_item(8'hFF, 8'hFF, 1'b0);

		// Gray: all sixteen indexes, a first half closed by row end, a second
		// half where row end changes nothing, and a half byte that survives a
		// mode change and merges afterwards.
		apply_mode(MODE_GRAY);
		send_item(8'h10, 8'h00, 1'b0);
		send_item(8'h32, 8'h00, 1'b0);
		send_item(8'h54, 8'hFF, 1'b1);
		send_item(8'h76, 8'h00, 1'b0);
		send_item(8'h98, 8'h00, 1'b1);
		send_item(8'hBA, 8'h00, 1'b0);
		send_item(8'hDC, 8'h00, 1'b0);
		send_item(8'hFE, 8'h00, 1'b1);
		send_item(8'h00, 8'h00, 1'b0);
		apply_mode(MODE_MONO);
		send_item(8'h5A, 8'hC3, 1'b0);
		apply_mode(MODE_GRAY);
		send_item(8'hFF, 8'h00, 1'b1);
		send_item(8'h0F, 8'h00, 1'b1);

		run_phase(MODE_MONO, 120, 1'b0);
		run_phase(MODE_GRAY, 150, 1'b0);
		run_phase(MODE_MONO_MIR, 120, 1'b0);
		run_phase(MODE_DIFF, 120, 1'b1);
		run_phase(MODE_GRAY, 150, 1'b1);
		run_phase(MODE_MONO, 100, 1'b0);
		run_phase(MODE_DIFF, 100, 1'b0);
		run_phase(MODE_GRAY, 150, 1'b0);

		in_if.valid = 1'b0;
		while (tracker.due_count() != 0) begin
			@(posedge clk);
		end
		repeat (2 * SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d framebuffer bytes through mono, mirrored mono, diff and gray4 modes,",
			items_sent);
		$display("checked %0d controller bytes, %0d gray bytes closed early by a row end.",
			tracker.bytes_checked, tracker.early_closes);
		if (tracker.bad_fields == 0 && tracker.due_count() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("%0d mismatched fields", tracker.bad_fields);
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/core/epfp_pkg.sv
rtl/core/epfp_in_if.sv
rtl/core/epfp_out_if.sv
rtl/core/epfp_format.sv
rtl/core/epfp_out_buf.sv
rtl/core/epaper_pixel_format_packer_top.sv
dv/epfp_tb_pkg.sv
dv/tb_top.sv
